/* design/fbm_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and widths for the fractal value noise core.
// No dependencies; imported by every module of the block.
package fbm_pkg;

    // Default octave depth of the cell chain
    localparam int MAX_OCTAVES_DEF = 8;

    // Accumulator widths, sized for up to 16 octaves
    localparam int SUM_W  = 45;
    localparam int NORM_W = 21;

    // Divider widths: dividend is sum << 16, divisor is norm * 0xFFFFFF
    localparam int DIVD_W = SUM_W + 16;
    localparam int DVS_W  = NORM_W + 24;
    localparam int Q_W    = 17;

    // Hash constants
    localparam logic [63:0] GOLDEN_INC = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_MUL_A  = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_MUL_B  = 64'h94D049BB133111EB;
    localparam logic [63:0] CELL_MUL_X = 64'hD2B74407B1CE6E93;
    localparam logic [63:0] CELL_MUL_Y = 64'h94A7C9870984AD17;

    // Fixed-point constants
    localparam logic [15:0] FREQ_ONE  = 16'd256;
    localparam logic [15:0] FREQ_MAX  = 16'hFFFF;
    localparam logic [16:0] AMP_ONE   = 17'd65536;
    localparam logic [16:0] AMP_MAX   = 17'h1FFFF;
    localparam logic [16:0] ONE_Q16   = 17'd65536;
    localparam logic [17:0] SMOOTH_3  = 18'd196608;
    localparam logic [15:0] NOISE_MAX = 16'hFFFF;

    // Configuration register indexes
    localparam int          CFG_IDX_W     = 2;
    localparam logic [1:0]  CFG_SEED      = 2'd0;
    localparam logic [1:0]  CFG_OCTAVES   = 2'd1;
    localparam logic [1:0]  CFG_LACUNARITY = 2'd2;
    localparam logic [1:0]  CFG_GAIN      = 2'd3;

    // Reset values of the configuration registers
    localparam logic [3:0]  OCTAVES_RST = 4'd4;
    localparam logic [15:0] LAC_RST     = 16'd512;
    localparam logic [16:0] GAIN_RST    = 17'd32768;

    // Configuration seen by every cell
    typedef struct packed {
        logic [63:0] seed;
        logic [15:0] lac;
        logic [16:0] gain;
    } fbm_cfg_t;

    // Item handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic [31:0]       cx;
        logic [31:0]       cy;
        logic [15:0]       freq;
        logic [16:0]       amp;
        logic [SUM_W-1:0]  sum;
        logic [NORM_W-1:0] norm;
    } fbm_bus_t;

endpackage

/* design/fbm_hash.sv */
`timescale 1ns / 1ps
// Four-stage pipelined splitmix64 finalizer giving a 24-bit corner value.
// Depends on fbm_pkg for the mix constants.
module fbm_hash
    import fbm_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] z_in,
    output logic [23:0] value
);

    logic [63:0] w1;
    logic [63:0] y_next;
    logic [63:0] w2;
    logic [63:0] r;

    logic [63:0] p0_reg;
    logic [31:0] p1_reg;
    logic [31:0] p2_reg;
    logic [63:0] y_reg;
    logic [63:0] q0_reg;
    logic [31:0] q1_reg;
    logic [31:0] q2_reg;
    logic [23:0] v_reg;

    // first xor-shift, 64x64 low product split into 32-bit partials
    assign w1 = z_in ^ (z_in >> 30);
    // recombine partials
    assign y_next = p0_reg + {32'(p1_reg + p2_reg), 32'd0};
    // second xor-shift
    assign w2 = y_reg ^ (y_reg >> 27);
    // recombine, final xor-shift; only the low 24 bits survive
    assign r = q0_reg + {32'(q1_reg + q2_reg), 32'd0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg <= w1[31:0] * MIX_MUL_A[31:0];
            p1_reg <= 32'(w1[31:0] * MIX_MUL_A[63:32]);
            p2_reg <= 32'(w1[63:32] * MIX_MUL_A[31:0]);
            y_reg  <= y_next;
            q0_reg <= w2[31:0] * MIX_MUL_B[31:0];
            q1_reg <= 32'(w2[31:0] * MIX_MUL_B[63:32]);
            q2_reg <= 32'(w2[63:32] * MIX_MUL_B[31:0]);
            v_reg  <= r[23:0] ^ r[54:31];
        end
    end

    assign value = v_reg;

endmodule

/* design/fbm_cell.sv */
`timescale 1ns / 1ps
// One octave cell: scales the point, hashes four lattice corners, blends,
// and adds the weighted sample to the running sum. Uses fbm_pkg, fbm_hash.
module fbm_cell
    import fbm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  fbm_cfg_t cfg,
    input  logic     active,
    input  fbm_bus_t bus_in,
    output fbm_bus_t bus_out
);

    localparam int CAR_N = 14;

    // Side data that travels along the cell's pipeline
    typedef struct packed {
        logic [31:0]       cx;
        logic [31:0]       cy;
        logic [15:0]       freq_nx;
        logic [16:0]       amp;
        logic [16:0]       amp_nx;
        logic [SUM_W-1:0]  sum;
        logic [NORM_W-1:0] norm;
        logic [15:0]       sx;
        logic [15:0]       sy;
    } car_t;

    car_t        car_reg  [CAR_N];
    car_t        car_next [CAR_N];
    logic        vld_reg  [CAR_N];
    fbm_bus_t    out_reg;

    logic signed [48:0] scx;
    logic signed [48:0] scy;
    logic [31:0]        fl;
    logic [33:0]        ag;
    logic [15:0]        freq_nx;
    logic [16:0]        amp_nx;

    logic [31:0]        px_reg;
    logic [31:0]        py_reg;

    logic signed [48:0] mxl_w;
    logic signed [48:0] mxh_w;
    logic signed [48:0] myl_w;
    logic signed [48:0] myh_w;
    logic signed [48:0] mxl_reg;
    logic [31:0]        mxh_reg;
    logic signed [48:0] myl_reg;
    logic [31:0]        myh_reg;
    logic [31:0]        ttx_reg;
    logic [31:0]        tty_reg;
    logic [17:0]        tkx_reg;
    logic [17:0]        tky_reg;

    logic [63:0]        hx0_reg;
    logic [63:0]        hy0_reg;
    logic [49:0]        ssx_reg;
    logic [49:0]        ssy_reg;

    logic [63:0]        hxa_reg;
    logic [63:0]        hxb_reg;
    logic [63:0]        hya_reg;
    logic [63:0]        hyb_reg;

    logic [63:0]        z_reg [4];
    logic [23:0]        v     [4];

    logic [40:0]        pa_reg [2];
    logic [40:0]        pb_reg [2];
    logic [40:0]        lsum   [2];
    logic [23:0]        lerp_reg [2];
    logic [40:0]        qa_reg;
    logic [40:0]        qb_reg;
    logic [40:0]        qsum;
    logic [23:0]        smp_reg;
    logic [40:0]        wprod_reg;

    // Point scaling and next-octave frequency and amplitude
    assign scx = $signed(bus_in.cx) * $signed({1'b0, bus_in.freq});
    assign scy = $signed(bus_in.cy) * $signed({1'b0, bus_in.freq});
    assign fl  = bus_in.freq * cfg.lac;
    assign ag  = bus_in.amp * cfg.gain;
    assign freq_nx = (fl[31:24] != 8'd0) ? FREQ_MAX : fl[23:8];
    assign amp_nx  = ag[33] ? AMP_MAX : ag[32:16];

    // Cell index times hash multiplier, split into 32-bit halves
    assign mxl_w = $signed(px_reg[31:16]) * $signed({1'b0, CELL_MUL_X[31:0]});
    assign mxh_w = $signed(px_reg[31:16]) * $signed({1'b0, CELL_MUL_X[63:32]});
    assign myl_w = $signed(py_reg[31:16]) * $signed({1'b0, CELL_MUL_Y[31:0]});
    assign myh_w = $signed(py_reg[31:16]) * $signed({1'b0, CELL_MUL_Y[63:32]});

    // Side data shift line; smoothstep results join at the fourth stage
    always_comb
    begin
        car_next[0].cx      = bus_in.cx;
        car_next[0].cy      = bus_in.cy;
        car_next[0].freq_nx = freq_nx;
        car_next[0].amp     = bus_in.amp;
        car_next[0].amp_nx  = amp_nx;
        car_next[0].sum     = bus_in.sum;
        car_next[0].norm    = bus_in.norm;
        car_next[0].sx      = 16'd0;
        car_next[0].sy      = 16'd0;
        for (int i = 1; i < CAR_N; i++)
        begin
            car_next[i] = car_reg[i-1];
        end
        car_next[3].sx = ssx_reg[47:32];
        car_next[3].sy = ssy_reg[47:32];
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CAR_N; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= bus_in.valid;
            for (int i = 1; i < CAR_N; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < CAR_N; i++)
            begin
                car_reg[i] <= car_next[i];
            end
        end
    end

    // Front end: scaling, index products, smoothstep, corner seeds
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg  <= scx[39:8];
            py_reg  <= scy[39:8];

            mxl_reg <= mxl_w;
            mxh_reg <= mxh_w[31:0];
            myl_reg <= myl_w;
            myh_reg <= myh_w[31:0];
            ttx_reg <= px_reg[15:0] * px_reg[15:0];
            tty_reg <= py_reg[15:0] * py_reg[15:0];
            tkx_reg <= SMOOTH_3 - {1'b0, px_reg[15:0], 1'b0};
            tky_reg <= SMOOTH_3 - {1'b0, py_reg[15:0], 1'b0};

            hx0_reg <= {{15{mxl_reg[48]}}, mxl_reg} + {mxh_reg, 32'd0};
            hy0_reg <= {{15{myl_reg[48]}}, myl_reg} + {myh_reg, 32'd0};
            ssx_reg <= ttx_reg * tkx_reg;
            ssy_reg <= tty_reg * tky_reg;

            // neighbor index term is the base term plus the multiplier
            hxa_reg <= hx0_reg;
            hxb_reg <= hx0_reg + CELL_MUL_X;
            hya_reg <= hy0_reg;
            hyb_reg <= hy0_reg + CELL_MUL_Y;

            z_reg[0] <= (cfg.seed ^ hxa_reg ^ hya_reg) + GOLDEN_INC;
            z_reg[1] <= (cfg.seed ^ hxb_reg ^ hya_reg) + GOLDEN_INC;
            z_reg[2] <= (cfg.seed ^ hxa_reg ^ hyb_reg) + GOLDEN_INC;
            z_reg[3] <= (cfg.seed ^ hxb_reg ^ hyb_reg) + GOLDEN_INC;
        end
    end

    // Corner hashes: 00, 10, 01, 11
    for (genvar g = 0; g < 4; g++)
    begin : g_hash
        fbm_hash u_hash (
            .clk   (clk),
            .en    (en),
            .z_in  (z_reg[g]),
            .value (v[g])
        );
    end

    assign lsum[0] = pa_reg[0] + pb_reg[0];
    assign lsum[1] = pa_reg[1] + pb_reg[1];
    assign qsum    = qa_reg + qb_reg;

    // Back end: bilinear blend and weighting
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg[0] <= v[0] * 17'(ONE_Q16 - {1'b0, car_reg[8].sx});
            pb_reg[0] <= v[1] * car_reg[8].sx;
            pa_reg[1] <= v[2] * 17'(ONE_Q16 - {1'b0, car_reg[8].sx});
            pb_reg[1] <= v[3] * car_reg[8].sx;

            lerp_reg[0] <= lsum[0][39:16];
            lerp_reg[1] <= lsum[1][39:16];

            qa_reg <= lerp_reg[0] * 17'(ONE_Q16 - {1'b0, car_reg[10].sy});
            qb_reg <= lerp_reg[1] * car_reg[10].sy;

            smp_reg   <= qsum[39:16];
            wprod_reg <= smp_reg * car_reg[12].amp;
        end
    end

    // Output stage: accumulate when this octave is in use
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            out_reg.valid <= vld_reg[CAR_N-1];
            out_reg.cx    <= car_reg[CAR_N-1].cx;
            out_reg.cy    <= car_reg[CAR_N-1].cy;
            out_reg.freq  <= car_reg[CAR_N-1].freq_nx;
            out_reg.amp   <= car_reg[CAR_N-1].amp_nx;
            if (active)
            begin
                out_reg.sum  <= car_reg[CAR_N-1].sum + SUM_W'(wprod_reg);
                out_reg.norm <= car_reg[CAR_N-1].norm + NORM_W'(car_reg[CAR_N-1].amp);
            end
            else
            begin
                out_reg.sum  <= car_reg[CAR_N-1].sum;
                out_reg.norm <= car_reg[CAR_N-1].norm;
            end
        end
    end

    assign bus_out = out_reg;

endmodule

/* design/fbm_div.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider: (sum << 16) / (norm * 0xFFFFFF), saturated.
// One quotient bit per stage. Depends on fbm_pkg.
module fbm_div
    import fbm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [SUM_W-1:0]  sum,
    input  logic [NORM_W-1:0] norm,
    output logic              out_valid,
    output logic [15:0]       value
);

    logic              p_valid_reg;
    logic [DIVD_W-1:0] p_rem_reg;
    logic [DVS_W-1:0]  p_dvs_reg;
    logic              p_zero_reg;

    logic              st_valid_reg [Q_W];
    logic [DIVD_W-1:0] st_rem_reg   [Q_W];
    logic [DVS_W-1:0]  st_dvs_reg   [Q_W];
    logic [Q_W-1:0]    st_q_reg     [Q_W];
    logic              st_zero_reg  [Q_W];

    // Prep stage: divisor is norm * 0xFFFFFF as a shift and subtract
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_rem_reg  <= {sum, 16'd0};
            p_dvs_reg  <= (DVS_W'(norm) << 24) - DVS_W'(norm);
            p_zero_reg <= (norm == '0);
        end
    end

    // Quotient stages, most significant bit first
    for (genvar g = 0; g < Q_W; g++)
    begin : g_stage
        localparam int SH = Q_W - 1 - g;

        logic              src_valid;
        logic [DIVD_W-1:0] src_rem;
        logic [DVS_W-1:0]  src_dvs;
        logic [Q_W-1:0]    src_q;
        logic              src_zero;
        logic [DIVD_W-1:0] dvs_sh;

        if (g == 0)
        begin : g_first
            assign src_valid = p_valid_reg;
            assign src_rem   = p_rem_reg;
            assign src_dvs   = p_dvs_reg;
            assign src_q     = '0;
            assign src_zero  = p_zero_reg;
        end
        else
        begin : g_rest
            assign src_valid = st_valid_reg[g-1];
            assign src_rem   = st_rem_reg[g-1];
            assign src_dvs   = st_dvs_reg[g-1];
            assign src_q     = st_q_reg[g-1];
            assign src_zero  = st_zero_reg[g-1];
        end

        assign dvs_sh = DIVD_W'(src_dvs) << SH;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                st_valid_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                st_valid_reg[g] <= src_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_dvs_reg[g]  <= src_dvs;
                st_zero_reg[g] <= src_zero;
                if (src_rem >= dvs_sh)
                begin
                    st_rem_reg[g] <= src_rem - dvs_sh;
                    st_q_reg[g]   <= src_q | (Q_W'(1) << SH);
                end
                else
                begin
                    st_rem_reg[g] <= src_rem;
                    st_q_reg[g]   <= src_q;
                end
            end
        end
    end

    // Saturate; an empty amplitude sum yields zero
    assign out_valid = st_valid_reg[Q_W-1];
    assign value = st_zero_reg[Q_W-1] ? 16'd0 :
                   (st_q_reg[Q_W-1][Q_W-1] ? NOISE_MAX : st_q_reg[Q_W-1][15:0]);

endmodule

/* design/fbm_value_noise_2d_core.sv */
`timescale 1ns / 1ps
// Top level of the 2D fractal value noise core: config registers, octave
// cell chain, divider and output buffer. Uses fbm_pkg, fbm_cell, fbm_div.
//
// Usage:
//   Points enter on in_valid/in_ready with coord_x, coord_y (signed Q16.16).
//   Each point gives one noise_value (unsigned Q0.16) on out_valid/out_ready,
//   in the order the points were taken.
//   Configuration (seed, octave_count, lacunarity, gain) is written through
//   cfg_we/cfg_index/cfg_data while the core holds no point.
//   One transfer per cycle is sustained while results are taken: one cell
//   per octave, each a 15-stage pipeline, then a 17-stage divider with one
//   prep stage, then the output buffer register.
//   A two-entry output buffer sits at the end. While the receiver stalls the
//   core keeps taking points until the buffer holds two results; then the
//   whole pipeline holds and in_ready drops until a result is taken.
//   Reset clears all valid bits and the buffer and loads the register
//   defaults: seed 0, four octaves, lacunarity 2.0, gain 0.5.
module fbm_value_noise_2d_core
    import fbm_pkg::*;
#(
    parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [31:0]          coord_x,
    input  logic [31:0]          coord_y,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [15:0]          noise_value,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data
);

    localparam logic [1:0] BUF_FULL = 2'd2;

    logic [63:0] seed_reg;
    logic [3:0]  oct_reg;
    logic [15:0] lac_reg;
    logic [16:0] gain_reg;

    fbm_cfg_t    cfg;
    logic [4:0]  n_eff;
    logic        en;
    fbm_bus_t    bus [MAX_OCTAVES + 1];

    logic        div_valid;
    logic [15:0] div_value;

    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic [15:0] d0_reg;
    logic [15:0] d0_next;
    logic [15:0] d1_reg;
    logic [15:0] d1_next;
    logic        push;
    logic        pop;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= 64'd0;
            oct_reg  <= OCTAVES_RST;
            lac_reg  <= LAC_RST;
            gain_reg <= GAIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SEED:       seed_reg <= cfg_data;
                CFG_OCTAVES:    oct_reg  <= cfg_data[3:0];
                CFG_LACUNARITY: lac_reg  <= cfg_data[15:0];
                CFG_GAIN:       gain_reg <= cfg_data[16:0];
                default:        ;
            endcase
        end
    end

    assign cfg.seed = seed_reg;
    assign cfg.lac  = lac_reg;
    assign cfg.gain = gain_reg;

    // Octave count clamped to the chain length
    assign n_eff = ({1'b0, oct_reg} > 5'(MAX_OCTAVES)) ? 5'(MAX_OCTAVES)
                                                      : {1'b0, oct_reg};

    // Pipeline advances while the output buffer has room
    assign en       = (cnt_reg != BUF_FULL);
    assign in_ready = en;

    // Chain entry
    assign bus[0].valid = in_valid;
    assign bus[0].cx    = coord_x;
    assign bus[0].cy    = coord_y;
    assign bus[0].freq  = FREQ_ONE;
    assign bus[0].amp   = AMP_ONE;
    assign bus[0].sum   = '0;
    assign bus[0].norm  = '0;

    // Octave cells
    for (genvar k = 0; k < MAX_OCTAVES; k++)
    begin : g_cell
        fbm_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .cfg     (cfg),
            .active  (5'(k) < n_eff),
            .bus_in  (bus[k]),
            .bus_out (bus[k+1])
        );
    end

    // Normalization
    fbm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (bus[MAX_OCTAVES].valid),
        .sum       (bus[MAX_OCTAVES].sum),
        .norm      (bus[MAX_OCTAVES].norm),
        .out_valid (div_valid),
        .value     (div_value)
    );

    // Two-entry output buffer
    assign push = en && div_valid;
    assign pop  = (cnt_reg != 2'd0) && out_ready;

    always_comb
    begin
        d0_next  = d0_reg;
        d1_next  = d1_reg;
        cnt_next = 2'(cnt_reg + {1'b0, push} - {1'b0, pop});
        case ({push, pop})
            2'b10:
            begin
                if (cnt_reg == 2'd0)
                begin
                    d0_next = div_value;
                end
                else
                begin
                    d1_next = div_value;
                end
            end
            2'b01:
            begin
                d0_next = d1_reg;
            end
            2'b11:
            begin
                if (cnt_reg == 2'd1)
                begin
                    d0_next = div_value;
                end
                else
                begin
                    d0_next = d1_reg;
                    d1_next = div_value;
                end
            end
            default:
            begin
                d0_next = d0_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d0_reg <= d0_next;
        d1_reg <= d1_next;
    end

    assign out_valid   = (cnt_reg != 2'd0);
    assign noise_value = d0_reg;

endmodule
